/* src/qswg_pkg.sv */
// Shared types and constants for the quadrature square-wave generator.
`default_nettype none

package qswg_pkg;

  // Field widths
  localparam int unsigned ClkW  = 28;
  localparam int unsigned FreqW = 28;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned StatW = 2;
  localparam int unsigned OutW  = 16;

  // Quotient width of the period division (numerator clock + f)
  localparam int unsigned QuotW  = ClkW + 1;
  localparam int unsigned StepCntW = $clog2(QuotW);

  // Command codes
  localparam logic [CmdW-1:0] CmdSetFreq = 2'd0;
  localparam logic [CmdW-1:0] CmdStop    = 2'd1;
  localparam logic [CmdW-1:0] CmdTick    = 2'd2;

  // Status codes
  localparam logic [StatW-1:0] StatOk      = 2'd0;
  localparam logic [StatW-1:0] StatZero    = 2'd1;
  localparam logic [StatW-1:0] StatTooLow  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic do_step;     // execute a transaction that needs no division and load its result
    logic div_start;   // latch operands of the period division
    logic div_step;    // one quotient bit
    logic div_finish;  // apply the new period and load the result
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic needs_div;   // incoming transaction is a non-zero set-frequency
    logic div_last;    // current division step is the final one
  } dp_status_t;

endpackage

`default_nettype wire

/* src/qswg_ctrl.sv */
// Controller state machine: input acceptance, division sequencing, result valid.
`default_nettype none

module qswg_ctrl
  import qswg_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == StIdle) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Sequence commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (status_i.needs_div) begin
            cmd_o.div_start = 1'b1;
            state_d = StDiv;
          end else begin
            cmd_o.do_step = 1'b1;
          end
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          cmd_o.div_finish = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold result valid until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.do_step || cmd_o.div_finish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* src/qswg_datapath.sv */
// Datapath: clock register, period divider, counter and quadrature levels.
`default_nettype none

module qswg_datapath
  import qswg_pkg::*;
#(
  parameter int unsigned MAX_TOP = 65535
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [ClkW-1:0]  cfg_data_i,
  input  wire logic [CmdW-1:0]  command_i,
  input  wire logic [FreqW-1:0] freq_hz_i,
  input  wire ctrl_cmd_t        cmd_i,
  output dp_status_t            status_o,
  output logic [StatW-1:0]      status_res_o,
  output logic [OutW-1:0]       period_value_o,
  output logic [OutW-1:0]       phase_offset_o,
  output logic                  lead_level_o,
  output logic                  lag_level_o,
  output logic                  outputs_enabled_o
);

  localparam int unsigned CntW = $clog2(MAX_TOP + 1);
  localparam logic [QuotW-1:0] MaxCounts = QuotW'(MAX_TOP + 1);
  localparam logic [QuotW-1:0] MinCounts = QuotW'(2);
  localparam logic [StepCntW-1:0] LastStep = StepCntW'(QuotW - 1);

  logic [ClkW-1:0]     clk_hz_q;
  logic [QuotW-1:0]    num_q, num_d;
  logic [QuotW-1:0]    den_q, den_d;
  logic [QuotW-1:0]    rem_q, rem_d;
  logic [QuotW-1:0]    quo_q, quo_d;
  logic [StepCntW-1:0] step_q, step_d;
  logic [QuotW:0]      rem_sh;
  logic [QuotW:0]      rem_sub;
  logic                rem_ge;

  logic                running_q, running_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     top_q, top_d;
  logic [CntW-1:0]     offs_q, offs_d;
  logic                lead_q, lead_d;
  logic                lag_q, lag_d;
  logic [StatW-1:0]    stat_q, stat_d;

  logic [QuotW-1:0]    counts;
  logic [CntW-1:0]     new_top;
  logic [CntW-1:0]     new_offs;

  // Timer clock register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= ClkW'(99840000);
    end else if (cfg_we_i) begin
      clk_hz_q <= cfg_data_i;
    end
  end

  assign status_o.needs_div = (command_i == CmdSetFreq) && (freq_hz_i != '0);
  assign status_o.div_last  = (step_q == LastStep);

  // Restoring divider, one quotient bit a cycle
  assign rem_sh  = {rem_q, num_q[QuotW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign rem_ge  = rem_sh >= {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    if (cmd_i.div_start) begin
      num_d  = {1'b0, clk_hz_q} + {1'b0, freq_hz_i};
      den_d  = {freq_hz_i, 1'b0};
      rem_d  = '0;
      quo_d  = '0;
      step_d = '0;
    end else if (cmd_i.div_step) begin
      num_d  = {num_q[QuotW-2:0], 1'b0};
      rem_d  = rem_ge ? rem_sub[QuotW-1:0] : rem_sh[QuotW-1:0];
      quo_d  = {quo_q[QuotW-2:0], rem_ge};
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    step_q <= step_d;
  end

  // Clamp the period to the minimum and derive top and offset
  assign counts   = (quo_q < MinCounts) ? MinCounts : quo_q;
  assign new_top  = CntW'(counts - 1'b1);
  assign new_offs = CntW'(counts >> 1);

  // Generator state and result status
  always_comb begin
    running_d = running_q;
    count_d   = count_q;
    top_d     = top_q;
    offs_d    = offs_q;
    lead_d    = lead_q;
    lag_d     = lag_q;
    stat_d    = stat_q;
    if (cmd_i.div_finish) begin
      if (counts > MaxCounts) begin
        stat_d = StatTooLow;
      end else begin
        stat_d = StatOk;
        top_d  = new_top;
        offs_d = new_offs;
        if (!running_q) begin
          count_d   = '0;
          lead_d    = 1'b0;
          lag_d     = 1'b0;
          running_d = 1'b1;
        end else if (count_q > new_top) begin
          count_d = '0;
        end
      end
    end else if (cmd_i.do_step) begin
      stat_d = StatOk;
      case (command_i)
        CmdSetFreq: begin
          stat_d = StatZero;
        end
        CmdStop: begin
          running_d = 1'b0;
          count_d   = '0;
          lead_d    = 1'b0;
          lag_d     = 1'b0;
        end
        CmdTick: begin
          if (running_q) begin
            if (count_q == '0) begin
              lead_d = !lead_q;
            end
            if (count_q == offs_q) begin
              lag_d = !lag_q;
            end
            count_d = (count_q >= top_q) ? '0 : count_q + 1'b1;
          end
        end
        default: begin
          stat_d = StatOk;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      count_q   <= '0;
      top_q     <= '0;
      offs_q    <= '0;
      lead_q    <= 1'b0;
      lag_q     <= 1'b0;
      stat_q    <= StatOk;
    end else begin
      running_q <= running_d;
      count_q   <= count_d;
      top_q     <= top_d;
      offs_q    <= offs_d;
      lead_q    <= lead_d;
      lag_q     <= lag_d;
      stat_q    <= stat_d;
    end
  end

  // State changes only when a result loads, so it doubles as the result
  assign status_res_o      = stat_q;
  assign period_value_o    = OutW'(top_q);
  assign phase_offset_o    = OutW'(offs_q);
  assign lead_level_o      = lead_q;
  assign lag_level_o       = lag_q;
  assign outputs_enabled_o = running_q;

endmodule

`default_nettype wire

/* src/quadrature_square_wave_generator_core.sv */
// Top level of the quadrature square-wave generator.
`default_nettype none

// Two square waves a quarter period apart, advanced by tick transactions.
// Tick, stop, unused and zero set-frequency commands need no division, so
// ticks stream at one per cycle while the result side keeps up. A non-zero
// set-frequency transaction latches the operands, runs the radix-2
// restoring divider that forms round(timer_clock_hz / (2*f)), then applies
// the new period and posts the result once the result side is free. Every
// transaction returns exactly one result; the input stalls while a stalled
// result is held or the divider is busy. The timer clock register may be
// written at any time the generator is idle; its port is always ready.
module quadrature_square_wave_generator_core
  import qswg_pkg::*;
#(
  parameter int unsigned MAX_TOP = 65535
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [ClkW-1:0]  cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [CmdW-1:0]  command_i,
  input  wire logic [FreqW-1:0] freq_hz_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [StatW-1:0]      status_o,
  output logic [OutW-1:0]       period_value_o,
  output logic [OutW-1:0]       phase_offset_o,
  output logic                  lead_level_o,
  output logic                  lag_level_o,
  output logic                  outputs_enabled_o
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  qswg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd)
  );

  qswg_datapath #(
    .MAX_TOP (MAX_TOP)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .command_i         (command_i),
    .freq_hz_i         (freq_hz_i),
    .cmd_i             (ctrl_cmd),
    .status_o          (dp_status),
    .status_res_o      (status_o),
    .period_value_o    (period_value_o),
    .phase_offset_o    (phase_offset_o),
    .lead_level_o      (lead_level_o),
    .lag_level_o       (lag_level_o),
    .outputs_enabled_o (outputs_enabled_o)
  );

endmodule

`default_nettype wire

/* sim/quadrature_square_wave_generator_core_test.sv */
// Self-checking testbench for the quadrature square-wave generator core.
`timescale 1ns / 1ps

module quadrature_square_wave_generator_core_test;
  import qswg_pkg::*;

  localparam int unsigned MaxTop = 65535;
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam logic [ClkW-1:0] ClockReset = 28'd99840000;
  localparam logic [ClkW-1:0] ClockMax = 28'hFFFFFFF;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned ChunkItems = 163;
  localparam int unsigned SettleCycles = 40;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [FreqW-1:0] freq;
  } wave_cmd_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [OutW-1:0]  period;
    logic [OutW-1:0]  offset;
    logic             lead;
    logic             lag;
    logic             enabled;
  } wave_state_t;

  // Clock, reset and block ports
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [ClkW-1:0]  cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [CmdW-1:0]  command = CmdTick;
  logic [FreqW-1:0] freq_hz = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [StatW-1:0] status;
  logic [OutW-1:0]  period_value;
  logic [OutW-1:0]  phase_offset;
  logic             lead_level;
  logic             lag_level;
  logic             outputs_enabled;

  // Generator model state
  logic [ClkW-1:0] timer_clock_hz = ClockReset;
  logic            gen_running = 1'b0;
  logic [OutW-1:0] gen_count = '0;
  logic [OutW-1:0] gen_top = '0;
  logic [OutW-1:0] gen_offset = '0;
  logic            gen_lead = 1'b0;
  logic            gen_lag = 1'b0;

  // Pending commands and expected wave states
  wave_cmd_t   command_q[$];
  wave_state_t wave_q[$];

  logic        cmd_in_flight = 1'b0;
  logic        idle_on = 1'b1;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned error_count = 0;

  quadrature_square_wave_generator_core #(
    .MAX_TOP(MaxTop)
  ) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .command_i        (command),
    .freq_hz_i        (freq_hz),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .period_value_o   (period_value),
    .phase_offset_o   (phase_offset),
    .lead_level_o     (lead_level),
    .lag_level_o      (lag_level),
    .outputs_enabled_o(outputs_enabled)
  );

  always #1 clk = ~clk;

  // Advance the generator model by one transaction and return its visible state
  function automatic wave_state_t advance_generator(logic [CmdW-1:0] cmd,
                                                    logic [FreqW-1:0] f);
    wave_state_t     r;
    longint unsigned counts;
    r.status = StatOk;
    case (cmd)
      CmdSetFreq: begin
        if (f == '0) begin
          r.status = StatZero;
        end else begin
          counts = (64'(timer_clock_hz) + 64'(f)) / (64'(f) << 1);
          if (counts < 2) counts = 2;
          if (counts > 64'(MaxTop) + 1) begin
            r.status = StatTooLow;
          end else begin
            gen_top = OutW'(counts - 1);
            gen_offset = OutW'(counts / 2);
            if (!gen_running) begin
              gen_count = '0;
              gen_lead = 1'b0;
              gen_lag = 1'b0;
              gen_running = 1'b1;
            end else if (gen_count > gen_top) begin
              gen_count = '0;
            end
          end
        end
      end
      CmdStop: begin
        gen_running = 1'b0;
        gen_count = '0;
        gen_lead = 1'b0;
        gen_lag = 1'b0;
      end
      CmdTick: begin
        if (gen_running) begin
          if (gen_count == '0) gen_lead = ~gen_lead;
          if (gen_count == gen_offset) gen_lag = ~gen_lag;
          if (gen_count >= gen_top) gen_count = '0;
          else gen_count = gen_count + 1'b1;
        end
      end
      default: ;
    endcase
    r.period = gen_top;
    r.offset = gen_offset;
    r.lead = gen_lead;
    r.lag = gen_lag;
    r.enabled = gen_running;
    return r;
  endfunction

  // Mostly short idle runs, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Pick a frequency that mostly lands on a short period for the current clock
  function automatic logic [FreqW-1:0] pick_frequency();
    int unsigned     mode;
    int unsigned     periods;
    logic [FreqW-1:0] f;
    mode = $urandom_range(0, 99);
    if (mode < 70) begin
      periods = $urandom_range(2, 24);
      f = FreqW'(timer_clock_hz / (2 * periods));
      if (f == '0) f = FreqW'($urandom_range(1, 3));
    end else if (mode < 85) begin
      f = FreqW'($urandom);
    end else if (mode < 95) begin
      f = FreqW'(timer_clock_hz / (2 * (MaxTop + 1)) + $urandom_range(0, 2));
    end else begin
      f = '0;
    end
    return f;
  endfunction

  // Build one random transaction: mostly ticks, with retunes and stops mixed in
  function automatic wave_cmd_t random_command();
    wave_cmd_t   c;
    int unsigned r;
    r = $urandom_range(0, 99);
    c.freq = FreqW'($urandom);
    if (r < 7) begin
      c.cmd = CmdSetFreq;
      c.freq = pick_frequency();
    end else if (r < 9) begin
      c.cmd = CmdStop;
    end else if (r < 11) begin
      c.cmd = CmdUnused;
    end else begin
      c.cmd = CmdTick;
    end
    return c;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic queue_command(input logic [CmdW-1:0] cmd, input logic [FreqW-1:0] f);
    wave_cmd_t c;
    c.cmd = cmd;
    c.freq = f;
    command_q.push_back(c);
  endtask

  // Hold until every queued transaction is accepted and answered
  task automatic wait_for_drain();
    while (command_q.size() != 0 || cmd_in_flight || wave_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timer_clock(input logic [ClkW-1:0] hz);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= hz;
    do @(posedge clk); while (!cfg_ready);
    timer_clock_hz = hz;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Input driver: present the next transaction, hold it while stalled
  always @(negedge clk) begin : drive_input
    wave_cmd_t c;
    if (!cmd_in_flight) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (command_q.size() != 0) begin
        c = command_q.pop_front();
        command <= c.cmd;
        freq_hz <= c.freq;
        in_valid <= 1'b1;
        cmd_in_flight = 1'b1;
        if (idle_on) send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (idle_on) stall_left = pick_gap();
    end
  end

  // Predict the wave state for each accepted transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      wave_q.push_back(advance_generator(command, freq_hz));
      cmd_in_flight = 1'b0;
    end
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin : watch_output
    wave_state_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (wave_q.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        want = wave_q.pop_front();
        check_field("status", status, want.status);
        check_field("period_value", period_value, want.period);
        check_field("phase_offset", phase_offset, want.offset);
        check_field("lead_level", lead_level, want.lead);
        check_field("lag_level", lag_level, want.lag);
        check_field("outputs_enabled", outputs_enabled, want.enabled);
      end
    end
  end

  // Stimulus sequence
  initial begin : run_stimulus
    logic [ClkW-1:0] phase_clock [NumPhases];
    phase_clock[0] = 28'd1000;
    phase_clock[1] = 28'd0;
    phase_clock[2] = 28'd1;
    phase_clock[3] = ClockMax;
    phase_clock[4] = ClkW'($urandom);
    phase_clock[5] = ClockReset;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: idle commands, rejections, start, retunes and stop
    queue_command(CmdTick, '1);
    queue_command(CmdStop, '0);
    queue_command(CmdUnused, '0);
    queue_command(CmdSetFreq, '0);
    queue_command(CmdSetFreq, 28'd1);
    queue_command(CmdSetFreq, 28'd761);
    queue_command(CmdSetFreq, 28'd762);
    repeat (3) queue_command(CmdTick, '0);
    // shrink to two counts while the count sits above the new top
    queue_command(CmdSetFreq, ClockMax);
    repeat (4) queue_command(CmdTick, 28'h5555555);
    queue_command(CmdSetFreq, 28'd9984000);
    repeat (6) queue_command(CmdTick, 28'hAAAAAAA);
    queue_command(CmdStop, '1);
    queue_command(CmdUnused, '1);
    queue_command(CmdTick, '0);
    wait_for_drain();

    // Random phases, one per timer clock setting
    for (int p = 0; p < NumPhases; p++) begin
      write_timer_clock(phase_clock[p]);
      idle_on = (p != 2);
      for (int chunk = 0; chunk < 2; chunk++) begin
        for (int i = 0; i < ChunkItems; i++) command_q.push_back(random_command());
        // pause the sender until every result is back
        wait_for_drain();
      end
    end

    repeat (SettleCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("TIMEOUT: results still outstanding");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
